// ===== src/sstq_pkg.sv =====
// ----------------------------------------------------------------------------
// sstq_pkg
// Shared types and constants of the sorted sleep timeout queue.
// ----------------------------------------------------------------------------
package sstq_pkg;

    // Fixed field widths
    localparam int TICK_STEP_W = 20;
    localparam int THREAD_W    = 4;
    localparam int TIME_W      = 32;
    localparam int STATUS_W    = 3;

    // Time constants
    localparam logic [TICK_STEP_W-1:0] TICK_STEP_RESET = 20'd10000;
    localparam logic [TIME_W-1:0]      ONE_SECOND_US   = 32'd1000000;

    // Most entries popped by one tick
    localparam int MAX_WAKE = 16;
    localparam int WAKE_W   = $clog2(MAX_WAKE);

    // Request types
    localparam logic REQ_SLEEP = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_QUEUED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_YIELDED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WOKEN   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;

    // Source of the result thread field
    localparam logic [1:0] SEL_REQ  = 2'd0;
    localparam logic [1:0] SEL_HEAD = 2'd1;
    localparam logic [1:0] SEL_ZERO = 2'd2;

    // Input item
    typedef struct packed {
        logic                req_type;
        logic [THREAD_W-1:0] thread_id;
        logic [TIME_W-1:0]   duration_us;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [THREAD_W-1:0] thread_out;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic                latch;
        logic                eval;
        logic                ins;
        logic                pop;
        logic                load;
        logic [STATUS_W-1:0] st;
        logic [1:0]          sel;
        logic                last;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_tick;
        logic dur_zero;
        logic dur_big;
        logic full;
        logic head_wake;
        logic next_wake;
        logic count_zero;
        logic count_one;
    } t_dp_sts;

endpackage

// ===== src/sstq_dp.sv =====
// ----------------------------------------------------------------------------
// sstq_dp
// Datapath: time counter, sorted queue cells, request and result registers.
// ----------------------------------------------------------------------------
module sstq_dp import sstq_pkg::*; #(
    parameter int MAX_SLEEPERS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [TICK_STEP_W-1:0] i_cfg_wdata,
    input  t_in_item               i_in_item,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    output t_out_item              o_out_item
);

    localparam int CW = $clog2(MAX_SLEEPERS + 1);

    t_in_item               r_req;
    logic [TIME_W-1:0]      r_now;
    logic [TICK_STEP_W-1:0] r_tick_step;
    logic [CW-1:0]          r_count;
    logic [THREAD_W-1:0]    r_thr [MAX_SLEEPERS];
    logic [TIME_W-1:0]      r_dl  [MAX_SLEEPERS];
    logic [MAX_SLEEPERS-1:0] r_pos;
    t_out_item              r_out;

    logic [MAX_SLEEPERS-1:0] n_pos;
    logic [MAX_SLEEPERS-1:0] w_before;
    logic [TIME_W-1:0]       w_rem0;
    logic [TIME_W-1:0]       w_rem1;
    logic [TIME_W-1:0]       w_new_dl;

    // Tick step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_step <= TICK_STEP_RESET;
        end else if (i_cfg_we) begin
            r_tick_step <= i_cfg_wdata;
        end
    end

    // Latched request
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_in_item;
        end
    end

    // Time counter, advanced once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now <= '0;
        end else if (i_cmd.eval && r_req.req_type == REQ_TICK) begin
            r_now <= r_now + TIME_W'(r_tick_step);
        end
    end

    // Per-cell position test: cell is at or past the insert point
    for (genvar gi = 0; gi < MAX_SLEEPERS; gi++) begin : g_cmp
        logic [TIME_W-1:0] w_rem;
        assign w_rem = r_dl[gi] - r_now;
        assign n_pos[gi] = (CW'(gi) < r_count) ? (w_rem >= r_req.duration_us)
                                               : (CW'(gi) == r_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_pos <= n_pos;
        end
    end

    // A cell shifts up when any lower cell holds the insert point
    assign w_before[0] = 1'b0;
    for (genvar gi = 1; gi < MAX_SLEEPERS; gi++) begin : g_before
        assign w_before[gi] = |r_pos[gi-1:0];
    end

    assign w_new_dl = r_now + r_req.duration_us;

    // Queue cells: insert shifts up, pop shifts down
    for (genvar gi = 0; gi < MAX_SLEEPERS; gi++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (i_cmd.ins) begin
                if (w_before[gi]) begin
                    r_thr[gi] <= r_thr[(gi > 0) ? gi - 1 : 0];
                    r_dl[gi]  <= r_dl[(gi > 0) ? gi - 1 : 0];
                end else if (r_pos[gi]) begin
                    r_thr[gi] <= r_req.thread_id;
                    r_dl[gi]  <= w_new_dl;
                end
            end else if (i_cmd.pop && gi < MAX_SLEEPERS - 1) begin
                r_thr[gi] <= r_thr[(gi < MAX_SLEEPERS - 1) ? gi + 1 : gi];
                r_dl[gi]  <= r_dl[(gi < MAX_SLEEPERS - 1) ? gi + 1 : gi];
            end
        end
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ins) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.pop) begin
            r_count <= r_count - CW'(1);
        end
    end

    // Head and next-cell wake tests: remaining time zero or negative
    assign w_rem0 = r_dl[0] - r_now;
    assign w_rem1 = r_dl[1] - r_now;

    always_comb begin
        o_sts.is_tick    = (r_req.req_type == REQ_TICK);
        o_sts.dur_zero   = (r_req.duration_us == '0);
        o_sts.dur_big    = (r_req.duration_us > ONE_SECOND_US);
        o_sts.full       = (r_count == CW'(MAX_SLEEPERS));
        o_sts.head_wake  = (w_rem0 == '0) || w_rem0[TIME_W-1];
        o_sts.next_wake  = (w_rem1 == '0) || w_rem1[TIME_W-1];
        o_sts.count_zero = (r_count == '0);
        o_sts.count_one  = (r_count == CW'(1));
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.status <= i_cmd.st;
            r_out.last   <= i_cmd.last;
            case (i_cmd.sel)
                SEL_REQ:  r_out.thread_out <= r_req.thread_id;
                SEL_HEAD: r_out.thread_out <= r_thr[0];
                default:  r_out.thread_out <= '0;
            endcase
        end
    end

    assign o_out_item = r_out;

    // Checks
    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins |-> (r_count < CW'(MAX_SLEEPERS)))
        else $error("insert into a full queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_count != '0))
        else $error("pop from an empty queue");

    a_tick_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && r_req.req_type == REQ_TICK && !i_cfg_we) |=>
        (r_now == $past(r_now) + TIME_W'($past(r_tick_step))))
        else $error("time not advanced by tick step");

endmodule

// ===== src/sstq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sstq_ctrl
// Controller: sequences request evaluation, insert, wake pops and results.
// ----------------------------------------------------------------------------
module sstq_ctrl import sstq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_INS  = 2'd2;
    localparam logic [1:0] S_WAKE = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [WAKE_W-1:0] r_wake_n;
    logic              r_out_valid;
    logic              w_out_free;
    logic              w_accept;
    logic              w_last_wake;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_last_wake = (r_wake_n == WAKE_W'(MAX_WAKE - 1)) || i_sts.count_one
                         || !i_sts.next_wake;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.sel = SEL_REQ;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.is_tick) begin
                    n_state = S_WAKE;
                end else if (i_sts.dur_zero || i_sts.dur_big || i_sts.full) begin
                    // immediate answer, queue untouched
                    if (w_out_free) begin
                        o_cmd.load = 1'b1;
                        o_cmd.last = 1'b1;
                        if (i_sts.dur_zero) begin
                            o_cmd.st = ST_YIELDED;
                        end else if (i_sts.dur_big) begin
                            o_cmd.st = ST_INVALID;
                        end else begin
                            o_cmd.st = ST_FULL;
                        end
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                if (w_out_free) begin
                    o_cmd.ins  = 1'b1;
                    o_cmd.load = 1'b1;
                    o_cmd.st   = ST_QUEUED;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_WAKE: begin
                if (w_out_free) begin
                    o_cmd.load = 1'b1;
                    if (!i_sts.count_zero && i_sts.head_wake) begin
                        o_cmd.pop  = 1'b1;
                        o_cmd.st   = ST_WOKEN;
                        o_cmd.sel  = SEL_HEAD;
                        o_cmd.last = w_last_wake;
                        if (w_last_wake) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        o_cmd.st   = ST_NONE;
                        o_cmd.sel  = SEL_ZERO;
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, wake count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wake_n    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.latch) begin
                r_wake_n <= '0;
            end else if (o_cmd.pop) begin
                r_wake_n <= r_wake_n + WAKE_W'(1);
            end
            if (o_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    // Checks
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> w_out_free)
        else $error("result register overwritten while stalled");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EVAL))
        else $error("accepted item not evaluated");

    a_wake_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.pop && r_wake_n == WAKE_W'(MAX_WAKE - 1)) |-> o_cmd.last)
        else $error("wake limit exceeded");

endmodule

// ===== src/sorted_sleep_timeout_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_sleep_timeout_queue
// Microsecond timer with a deadline-sorted queue of sleeping threads.
// ----------------------------------------------------------------------------
// A sleep request is taken in S_IDLE and then passes through S_EVAL, to
// compare every queue cell against the duration, and S_INS, to shift the
// cells, insert and load its answer. Yielded, invalid and full answers are
// loaded in S_EVAL. A tick advances the time in the cycle after it is
// taken and then gives one woken result per cycle while the result side
// does not stall, one per pop of the queue head, up to sixteen, or a
// single nothing-woken result. A stall on the result side holds the
// sequence in place. The next item is taken once the last result of the
// previous one is in the result register.
// ----------------------------------------------------------------------------
module sorted_sleep_timeout_queue import sstq_pkg::*; #(
    parameter int MAX_SLEEPERS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [TICK_STEP_W-1:0] i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_item
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Controller
    sstq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Datapath
    sstq_dp #(
        .MAX_SLEEPERS (MAX_SLEEPERS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_item  (o_out_item)
    );

endmodule
